// ===== src/rc4_pkg.sv =====
`timescale 1ns / 1ps

package rc4_pkg;

    // Default depth of the key store.
    localparam int RC4_KEY_MAX_DEFAULT = 256;

    // Width of a byte, of the permutation index and of the key length register.
    localparam int BYTE_W = 8;
    localparam int KLEN_W = 9;

    // Highest permutation index, closing the key schedule sweep.
    localparam logic [BYTE_W-1:0] PERM_LAST = 8'd255;

    // Reset value of the key length register.
    localparam logic [KLEN_W-1:0] KEY_LENGTH_RESET = 9'd16;

    // Register indexes of the configuration port.
    localparam logic REG_KEY_LENGTH = 1'b0;

    // Item kinds carried in tuser.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SCHED = 2'd1;
    localparam logic [1:0] CMD_CRYPT = 2'd2;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD_KEY,
        DP_SCHED_INIT,
        DP_SK_READ_N,
        DP_SK_READ_ACC,
        DP_SK_WRITE_N,
        DP_SK_WRITE_ACC,
        DP_CR_READ_I,
        DP_CR_READ_J,
        DP_CR_SWAP_I,
        DP_CR_FINISH
    } dp_op_t;

    // Command from controller to datapath.
    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic n_last;
        logic len_zero;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/rc4_stream_cipher.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Signals                                   Contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser s_tlast  command, key and data beats
// m_*       out        m_tvalid m_tready m_tdata m_tlast          crypted byte and keystream
// APB       in/out     psel penable pwrite paddr pwdata prdata    key_length at address 0
//
// A load beat is a single key store write and a crypt beat has its steps (read S[i], read S[j], swap with
// a read of S[S[i]+S[j]], final write) set by the single write port of the permutation
// memory. A schedule beat is an init step and 256 steps of two reads and two writes, or the init
// step alone when key_length is 0. One beat is worked on at a time; a result waits in the output
// register while the next beat is taken, and a crypt beat stalls in its final write while
// that register is full. After reset the permutation reads as zeros through written flags.

module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int KEY_MAX_BYTES = RC4_KEY_MAX_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key_index [7:0], key_byte [15:8], data_byte [23:16]
    input  logic [1:0]  s_tuser,   // cmd [1:0]
    input  logic        s_tlast,   // data_last
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte [7:0], keystream_byte [15:8]
    output logic        m_tlast,   // out_last
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [KLEN_W-1:0] key_length_reg;
    logic              cfg_wr;
    dp_cmd_t           cmd;
    dp_status_t        status;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_KEY_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= KEY_LENGTH_RESET;
        end
        else if (cfg_wr)
        begin
            key_length_reg <= pwdata[KLEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_KEY_LENGTH) ? 32'(key_length_reg) : '0;

    // Controller.
    rc4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .item_cmd (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    rc4_dp #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .key_length (key_length_reg),
        .key_index  (s_tdata[7:0]),
        .key_byte   (s_tdata[15:8]),
        .data_byte  (s_tdata[23:16]),
        .data_last  (s_tlast),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .status     (status)
    );

endmodule

// ===== src/rc4_ctrl.sv =====
`timescale 1ns / 1ps

module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic [1:0] item_cmd,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SK_RN,
        ST_SK_RA,
        ST_SK_WN,
        ST_SK_WA,
        ST_CR_RJ,
        ST_CR_SW,
        ST_CR_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    // Next state and the datapath operation for this cycle.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (item_cmd)
                        CMD_LOAD:
                        begin
                            cmd.op = DP_LOAD_KEY;
                        end
                        CMD_SCHED:
                        begin
                            cmd.op     = DP_SCHED_INIT;
                            state_next = status.len_zero ? ST_IDLE : ST_SK_RN;
                        end
                        CMD_CRYPT:
                        begin
                            cmd.op     = DP_CR_READ_I;
                            state_next = ST_CR_RJ;
                        end
                        default:
                        begin
                            cmd.op = DP_NOP;
                        end
                    endcase
                end
            end
            ST_SK_RN:
            begin
                cmd.op     = DP_SK_READ_N;
                state_next = ST_SK_RA;
            end
            ST_SK_RA:
            begin
                cmd.op     = DP_SK_READ_ACC;
                state_next = ST_SK_WN;
            end
            ST_SK_WN:
            begin
                cmd.op     = DP_SK_WRITE_N;
                state_next = ST_SK_WA;
            end
            ST_SK_WA:
            begin
                cmd.op     = DP_SK_WRITE_ACC;
                state_next = status.n_last ? ST_IDLE : ST_SK_RN;
            end
            ST_CR_RJ:
            begin
                cmd.op     = DP_CR_READ_J;
                state_next = ST_CR_SW;
            end
            ST_CR_SW:
            begin
                cmd.op     = DP_CR_SWAP_I;
                state_next = ST_CR_FIN;
            end
            ST_CR_FIN:
            begin
                // Hold here while the previous result still occupies the output.
                if (status.out_free)
                begin
                    cmd.op     = DP_CR_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and the registered ready flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

// ===== src/rc4_dp.sv =====
`timescale 1ns / 1ps

module rc4_dp
    import rc4_pkg::*;
#(
    parameter int KEY_MAX_BYTES = RC4_KEY_MAX_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [KLEN_W-1:0] key_length,
    input  logic [7:0]        key_index,
    input  logic [7:0]        key_byte,
    input  logic [7:0]        data_byte,
    input  logic              data_last,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [15:0]       m_tdata,  // out_byte [7:0], keystream_byte [15:8]
    output logic              m_tlast,  // out_last
    output dp_status_t        status
);

    localparam int KEY_AW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

    // Memories: permutation (simple dual port) and key store.
    logic [BYTE_W-1:0] perm_mem [256];
    logic [7:0]        key_mem  [KEY_MAX_BYTES];

    // Per-entry written flags; an unwritten entry reads as its index or zero.
    logic [255:0]      perm_vld_reg;
    logic              ident_reg;

    // Registered read side of the permutation memory.
    logic [7:0]        rd_data_reg;
    logic [7:0]        rd_addr_reg;
    logic              rd_vld_reg;
    logic [7:0]        key_rd_reg;

    // Generator and schedule state.
    logic [7:0]        i_reg;
    logic [7:0]        j_reg;
    logic [7:0]        n_reg;
    logic [7:0]        acc_reg;
    logic [KEY_AW-1:0] kidx_reg;
    logic [7:0]        i1_reg;
    logic [7:0]        j1_reg;
    logic [7:0]        a_reg;
    logic [7:0]        b_reg;
    logic [7:0]        t_reg;
    logic [7:0]        data_reg;
    logic              last_reg;

    // Output register.
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic [7:0]        ks_byte_reg;
    logic              out_last_reg;

    // Port control and intermediate values.
    logic              rd_en;
    logic [7:0]        rd_addr;
    logic              wr_en;
    logic [7:0]        wr_addr;
    logic [7:0]        wr_data;
    logic              key_wr_en;
    logic [7:0]        perm_q;
    logic [7:0]        acc_new;
    logic [7:0]        i1;
    logic [7:0]        j1;
    logic [7:0]        t_new;
    logic [7:0]        ks;
    logic [KLEN_W-1:0] len_sat;
    logic              out_free;

    // Value read from the permutation, with unwritten entries resolved.
    always_comb
    begin
        if (rd_vld_reg)
        begin
            perm_q = rd_data_reg;
        end
        else if (ident_reg)
        begin
            perm_q = rd_addr_reg;
        end
        else
        begin
            perm_q = '0;
        end
    end

    // Key length limited to the depth of the key store.
    assign len_sat  = (key_length > KLEN_W'(KEY_MAX_BYTES)) ? KLEN_W'(KEY_MAX_BYTES)
                                                             : key_length;
    assign acc_new  = 8'(acc_reg + perm_q + key_rd_reg);
    assign i1       = 8'(i_reg + 8'd1);
    assign j1       = 8'(j_reg + perm_q);
    assign t_new    = 8'(a_reg + perm_q);
    assign out_free = !out_valid_reg || m_tready;

    // Keystream byte: the read was taken before the swap, so forward the swapped values.
    always_comb
    begin
        priority if (t_reg == j1_reg)
        begin
            ks = a_reg;
        end
        else if (t_reg == i1_reg)
        begin
            ks = b_reg;
        end
        else
        begin
            ks = perm_q;
        end
    end

    // Memory port selection for each operation.
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = n_reg;
        wr_en     = 1'b0;
        wr_addr   = n_reg;
        wr_data   = perm_q;
        key_wr_en = 1'b0;
        unique case (cmd.op)
            DP_LOAD_KEY:
            begin
                key_wr_en = (KLEN_W'(key_index) < KLEN_W'(KEY_MAX_BYTES));
            end
            DP_SK_READ_N:
            begin
                rd_en   = 1'b1;
                rd_addr = n_reg;
            end
            DP_SK_READ_ACC:
            begin
                rd_en   = 1'b1;
                rd_addr = acc_new;
            end
            DP_SK_WRITE_N:
            begin
                wr_en   = 1'b1;
                wr_addr = n_reg;
                wr_data = perm_q;
            end
            DP_SK_WRITE_ACC:
            begin
                wr_en   = 1'b1;
                wr_addr = acc_reg;
                wr_data = a_reg;
            end
            DP_CR_READ_I:
            begin
                rd_en   = 1'b1;
                rd_addr = i1;
            end
            DP_CR_READ_J:
            begin
                rd_en   = 1'b1;
                rd_addr = j1;
            end
            DP_CR_SWAP_I:
            begin
                rd_en   = 1'b1;
                rd_addr = t_new;
                wr_en   = 1'b1;
                wr_addr = i1_reg;
                wr_data = perm_q;
            end
            DP_CR_FINISH:
            begin
                wr_en   = 1'b1;
                wr_addr = j1_reg;
                wr_data = a_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Permutation memory and key store.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            perm_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= perm_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (key_wr_en)
        begin
            key_mem[key_index[KEY_AW-1:0]] <= key_byte;
        end
        if (cmd.op == DP_SK_READ_N)
        begin
            key_rd_reg <= key_mem[kidx_reg];
        end
    end

    // Written flags of the permutation and the mode for unwritten entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_vld_reg <= '0;
            ident_reg    <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_vld_reg <= perm_vld_reg[rd_addr];
            end
            if (cmd.op == DP_SCHED_INIT)
            begin
                perm_vld_reg <= '0;
                ident_reg    <= (key_length != '0);
            end
            else if (wr_en)
            begin
                perm_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Indices of the generator and the schedule sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            j_reg    <= '0;
            n_reg    <= '0;
            acc_reg  <= '0;
            kidx_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                DP_SCHED_INIT:
                begin
                    i_reg    <= '0;
                    j_reg    <= '0;
                    n_reg    <= '0;
                    acc_reg  <= '0;
                    kidx_reg <= '0;
                end
                DP_SK_READ_ACC:
                begin
                    acc_reg <= acc_new;
                end
                DP_SK_WRITE_ACC:
                begin
                    n_reg <= 8'(n_reg + 8'd1);
                    if (KLEN_W'(kidx_reg) + KLEN_W'(1) == len_sat)
                    begin
                        kidx_reg <= '0;
                    end
                    else
                    begin
                        kidx_reg <= KEY_AW'(kidx_reg + KEY_AW'(1));
                    end
                end
                DP_CR_FINISH:
                begin
                    i_reg <= i1_reg;
                    j_reg <= j1_reg;
                end
                default:
                begin
                    n_reg <= n_reg;
                end
            endcase
        end
    end

    // Working values of the current item.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_SK_READ_ACC:
            begin
                a_reg <= perm_q;
            end
            DP_CR_READ_I:
            begin
                i1_reg   <= i1;
                data_reg <= data_byte;
                last_reg <= data_last;
            end
            DP_CR_READ_J:
            begin
                j1_reg <= j1;
                a_reg  <= perm_q;
            end
            DP_CR_SWAP_I:
            begin
                b_reg <= perm_q;
                t_reg <= t_new;
            end
            default:
            begin
                a_reg <= a_reg;
            end
        endcase
    end

    // Output beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == DP_CR_FINISH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_CR_FINISH)
        begin
            out_byte_reg <= data_reg ^ ks;
            ks_byte_reg  <= ks;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {ks_byte_reg, out_byte_reg};
    assign m_tlast         = out_last_reg;
    assign status.n_last   = (n_reg == PERM_LAST);
    assign status.len_zero = (key_length == '0);
    assign status.out_free = out_free;

endmodule
